// File: sv/lfsta_pkg.sv
// ----------------------------------------------------------------------------
// lfsta_pkg: shared types and constants of the lowest free slot allocator
// Holds the transaction payloads, the table entry layout and the codes used
// on the request and response channels.
// ----------------------------------------------------------------------------
package lfsta_pkg;

  // Slot index and subtree count widths.
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 10;
  // Partial sums of counts during the descent.
  localparam int PART_W = CNT_W + 4;
  localparam int STAT_W = 2;

  // Request function codes.
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Response status codes.
  localparam logic [STAT_W-1:0] ST_DONE        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_RELEASE = 2'd2;

  // Reset value of the slot limit register.
  localparam logic [IDX_W-1:0] SLOT_LIMIT_RESET = 10'd1023;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] want;
    logic [IDX_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  granted;
  } rsp_t;

  // One table entry: the slot's reserved mark and its node count.
  typedef struct packed {
    logic             mark;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

// File: sv/lowest_free_slot_tree_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_tree_allocator: lowest free slot allocator
// Hands out the lowest free slot at or above a requested minimum and takes
// slots back, using an implicit in-place binary tree of reserved counts.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each table access is a read state
// followed by an evaluate state that may write the entry back, and a
// transaction ends by loading the response register. An allocation climbs
// at most ten nodes, descends at most nine, rereads its slot and then
// updates up to nine further nodes of the left-ancestor chain; a release
// reads its slot and updates the same chain. The response is held in an
// output register, and a new request is taken while it waits. After reset
// the table is cleared one entry per cycle; requests stall during that pass
// while slot_limit writes are taken as usual.
module lowest_free_slot_tree_allocator #(
  parameter int TABLE_SIZE = 1023
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lfsta_pkg::IDX_W-1:0]      cfg_wr_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  lfsta_pkg::req_t                  req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output lfsta_pkg::rsp_t                  rsp
);

  localparam int DEPTH = (TABLE_SIZE < 1023) ? TABLE_SIZE : 1023;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [lfsta_pkg::IDX_W-1:0] DEPTH_V = lfsta_pkg::IDX_W'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CLIMB_RD, S_CLIMB_EV, S_DESC_RD, S_DESC_EV,
    S_FIN_RD, S_FIN_EV, S_REL_RD, S_REL_EV, S_CHAIN_RD, S_CHAIN_EV, S_DONE
  } state_t;

  state_t                              state;
  logic [AW-1:0]                       clr_idx;
  logic [lfsta_pkg::IDX_W-1:0]         slot_limit;
  logic [lfsta_pkg::IDX_W-1:0]         free_hint;
  logic [lfsta_pkg::IDX_W-1:0]         pos;
  logic [lfsta_pkg::IDX_W-1:0]         node;
  logic [lfsta_pkg::IDX_W-1:0]         span;
  logic [lfsta_pkg::CNT_W-1:0]         cpos;
  logic [lfsta_pkg::PART_W-1:0]        part;
  logic [lfsta_pkg::IDX_W-1:0]         chain_n;
  logic                                up;
  logic                                want_le;
  logic [lfsta_pkg::STAT_W-1:0]        res_status;
  logic [lfsta_pkg::IDX_W-1:0]         res_granted;

  // Table memory with registered read data.
  lfsta_pkg::entry_t                   mem [DEPTH];
  lfsta_pkg::entry_t                   rdata;
  logic                                rd_oob;
  logic                                mem_we;
  logic [lfsta_pkg::IDX_W-1:0]         mem_waddr;
  lfsta_pkg::entry_t                   mem_wdata;
  logic                                rd_en;
  logic [lfsta_pkg::IDX_W-1:0]         rd_addr;

  // Derived values.
  logic [lfsta_pkg::IDX_W-1:0]         bound;
  logic [lfsta_pkg::IDX_W-1:0]         pos_lzb;
  logic [lfsta_pkg::IDX_W-1:0]         pos_up;
  logic [lfsta_pkg::IDX_W-1:0]         span_half;
  logic [lfsta_pkg::IDX_W-1:0]         pos_base;
  logic [lfsta_pkg::IDX_W-1:0]         chain_base;
  logic [lfsta_pkg::CNT_W-1:0]         rd_cnt;
  logic [lfsta_pkg::CNT_W-1:0]         cnt_inc;
  logic [lfsta_pkg::CNT_W-1:0]         cnt_dec;
  logic [lfsta_pkg::PART_W-1:0]        desc_sum;
  logic                                desc_match;
  logic [lfsta_pkg::IDX_W-1:0]         start_pos;

  // Search arithmetic on the current node and the read data.
  always_comb begin
    bound      = (slot_limit < DEPTH_V) ? slot_limit : DEPTH_V;
    pos_up     = pos | (pos + 1'b1);
    pos_lzb    = pos_up ^ pos;
    span_half  = span >> 1;
    pos_base   = pos & (pos + 1'b1);
    chain_base = chain_n & (chain_n + 1'b1);
    rd_cnt     = rd_oob ? '0 : rdata.cnt;
    cnt_inc    = rdata.cnt + 1'b1;
    cnt_dec    = (rdata.cnt == '0) ? '0 : rdata.cnt - 1'b1;
    desc_sum   = part + lfsta_pkg::PART_W'(rd_cnt);
    desc_match = (lfsta_pkg::PART_W'(cpos) == desc_sum + lfsta_pkg::PART_W'(span));
    start_pos  = (req.want > free_hint) ? req.want : free_hint;
  end

  // Memory port control for each state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chain_n;
    mem_wdata = '0;
    rd_en     = 1'b0;
    rd_addr   = pos;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = lfsta_pkg::IDX_W'(clr_idx);
      end
      S_CLIMB_RD, S_FIN_RD, S_REL_RD: begin
        rd_en = (pos < DEPTH_V);
      end
      S_DESC_RD: begin
        rd_addr = pos + span_half;
        rd_en   = (span_half != '0) && (rd_addr < DEPTH_V);
      end
      S_FIN_EV: begin
        mem_we         = !rdata.mark;
        mem_waddr      = pos;
        mem_wdata.mark = 1'b1;
        mem_wdata.cnt  = cnt_inc;
      end
      S_REL_EV: begin
        mem_we         = rdata.mark;
        mem_waddr      = pos;
        mem_wdata.mark = 1'b0;
        mem_wdata.cnt  = cnt_dec;
      end
      S_CHAIN_RD: begin
        rd_addr = chain_n;
        rd_en   = 1'b1;
      end
      S_CHAIN_EV: begin
        mem_we         = 1'b1;
        mem_wdata.mark = rdata.mark;
        mem_wdata.cnt  = up ? cnt_inc : cnt_dec;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[AW-1:0]] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr[AW-1:0]];
    end
    rd_oob <= (rd_addr >= DEPTH_V);
  end

  assign req_stall = (state != S_IDLE);

  // Sequencer: search, reserve or release, then walk the count chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      slot_limit <= lfsta_pkg::SLOT_LIMIT_RESET;
      free_hint  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slot_limit <= cfg_wr_data;
      end
      // The done state reloads the output register itself.
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            res_granted <= '0;
            if (req.func == lfsta_pkg::FUNC_RELEASE) begin
              pos <= req.slot;
              up  <= 1'b0;
              if (req.slot >= DEPTH_V) begin
                res_status <= lfsta_pkg::ST_BAD_RELEASE;
                state      <= S_DONE;
              end else begin
                state <= S_REL_RD;
              end
            end else begin
              want_le <= (req.want <= free_hint);
              pos     <= start_pos;
              up      <= 1'b1;
              state   <= S_CLIMB_RD;
            end
          end
        end
        S_CLIMB_RD: begin
          if (pos >= bound) begin
            res_status <= lfsta_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            state <= S_CLIMB_EV;
          end
        end
        S_CLIMB_EV: begin
          if (rdata.cnt == '0) begin
            state <= S_FIN_RD;
          end else if (rdata.cnt == pos_lzb) begin
            pos   <= pos_up;
            state <= S_CLIMB_RD;
          end else begin
            cpos  <= rdata.cnt;
            part  <= '0;
            span  <= pos_lzb;
            state <= S_DESC_RD;
          end
        end
        S_DESC_RD: begin
          if (span_half == '0) begin
            state <= S_FIN_RD;
          end else begin
            span  <= span_half;
            node  <= pos + span_half;
            state <= S_DESC_EV;
          end
        end
        S_DESC_EV: begin
          // Step right when the node and the left part are all reserved.
          if (desc_match) begin
            pos  <= node;
            cpos <= rd_cnt;
            part <= '0;
            state <= (rd_cnt == '0) ? S_FIN_RD : S_DESC_RD;
          end else begin
            part  <= desc_sum;
            state <= S_DESC_RD;
          end
        end
        S_FIN_RD: begin
          if (pos >= bound) begin
            res_status <= lfsta_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            state <= S_FIN_EV;
          end
        end
        S_FIN_EV: begin
          if (rdata.mark) begin
            res_status <= lfsta_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            res_status  <= lfsta_pkg::ST_DONE;
            res_granted <= pos;
            if (want_le) begin
              free_hint <= pos;
            end
            chain_n <= pos_base - 1'b1;
            state   <= (pos_base == '0) ? S_DONE : S_CHAIN_RD;
          end
        end
        S_REL_RD: begin
          state <= S_REL_EV;
        end
        S_REL_EV: begin
          if (!rdata.mark) begin
            res_status <= lfsta_pkg::ST_BAD_RELEASE;
            state      <= S_DONE;
          end else begin
            res_status <= lfsta_pkg::ST_DONE;
            if (pos < free_hint) begin
              free_hint <= pos;
            end
            chain_n <= pos_base - 1'b1;
            state   <= (pos_base == '0) ? S_DONE : S_CHAIN_RD;
          end
        end
        S_CHAIN_RD: begin
          state <= S_CHAIN_EV;
        end
        S_CHAIN_EV: begin
          chain_n <= chain_base - 1'b1;
          state   <= (chain_base == '0) ? S_DONE : S_CHAIN_RD;
        end
        S_DONE: begin
          // Load the output register once it is free.
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid   <= 1'b1;
            rsp.status  <= res_status;
            rsp.granted <= res_granted;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A refused transaction, whatever its function, never reports a slot number.
  a_granted_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != lfsta_pkg::ST_DONE) |-> rsp.granted == '0)
    else $error("granted slot reported on a failed transaction");

  // Requests stay stalled during the clearing pass.
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> req_stall)
    else $error("request taken during table clear");

  // The table is never written while waiting for a request.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  // Leaving the done state always presents a response.
  a_done_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!rsp_valid || !rsp_stall) |=> rsp_valid)
    else $error("finished transaction not presented");

  // The search hint always names a slot inside the table.
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    free_hint < DEPTH_V)
    else $error("free hint outside the table");

endmodule

// File: bench/slot_grant_checker.sv
// ----------------------------------------------------------------------------
// slot_grant_checker: response checker for the lowest free slot allocator
// Watches the configuration port and both transaction channels, predicts
// each response from a private copy of the slot tree, and compares every
// accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_grant_checker #(
  parameter int TABLE_SIZE = 1023
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lfsta_pkg::IDX_W-1:0]   cfg_wr_data,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  lfsta_pkg::req_t               req,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  lfsta_pkg::rsp_t               rsp,
  output int                            fail_cnt,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the allocator state.
  int unsigned node_cnt [TABLE_SIZE];
  bit          taken    [TABLE_SIZE];
  int unsigned hint;
  int unsigned limit_q;

  // Responses that have been predicted but not yet seen.
  lfsta_pkg::rsp_t due_responses [$];

  // Nodes past the end of the table read as empty.
  function automatic int unsigned node_count(int unsigned n);
    return (n < TABLE_SIZE) ? node_cnt[n] : 0;
  endfunction

  // Raise or lower the counts along the left-ancestor chain of a slot.
  function automatic void walk_chain(int unsigned n, bit up);
    bit last;
    last = 1'b0;
    while (!last) begin
      if (n < TABLE_SIZE) begin
        if (up) begin
          node_cnt[n]++;
        end else if (node_cnt[n] > 0) begin
          node_cnt[n]--;
        end
      end
      if ((n & (n + 1)) == 0) begin
        last = 1'b1;
      end else begin
        n = (n & (n + 1)) - 1;
      end
    end
  endfunction

  // Apply one request to the shadow state and return the response it causes.
  function automatic lfsta_pkg::rsp_t allocate_or_release(lfsta_pkg::req_t r);
    lfsta_pkg::rsp_t res;
    int unsigned     bound;
    int unsigned     pos;
    int unsigned     span;
    int unsigned     part;
    int unsigned     node;
    bit              hit;
    bit              stop;
    res.status  = lfsta_pkg::ST_DONE;
    res.granted = '0;

    // A release must name a reserved slot inside the table.
    if (r.func == lfsta_pkg::FUNC_RELEASE) begin
      if (r.slot >= TABLE_SIZE || !taken[r.slot]) begin
        res.status = lfsta_pkg::ST_BAD_RELEASE;
      end else begin
        taken[r.slot] = 1'b0;
        walk_chain(r.slot, 1'b0);
        if (r.slot < hint) hint = r.slot;
      end
      return res;
    end

    // Climb right ancestors until a subtree with room, then descend left.
    bound = (limit_q < TABLE_SIZE) ? limit_q : TABLE_SIZE;
    pos   = (r.want > hint) ? r.want : hint;
    hit   = 1'b0;
    while (!hit && pos < bound) begin
      span = pos ^ (pos | (pos + 1));
      if (node_count(pos) == 0) begin
        hit = 1'b1;
      end else if (node_count(pos) == span) begin
        pos = pos | (pos + 1);
      end else begin
        part = 0;
        stop = 1'b0;
        span = span >> 1;
        while (span > 0 && !stop) begin
          node = pos + span;
          part += node_count(node);
          if (node_count(pos) == part + span) begin
            pos = node;
            if (node_count(node) == 0) begin
              stop = 1'b1;
            end else begin
              part = 0;
            end
          end
          if (!stop) span = span >> 1;
        end
        hit = 1'b1;
      end
    end

    // Nothing usable below the bound leaves the state untouched.
    if (!hit || pos >= bound || taken[pos]) begin
      res.status = lfsta_pkg::ST_FULL;
      return res;
    end
    if (r.want <= hint) hint = pos;
    taken[pos] = 1'b1;
    walk_chain(pos, 1'b1);
    res.granted = lfsta_pkg::IDX_W'(pos);
    return res;
  endfunction

  // Sample the channels at each rising edge.
  always @(posedge clk) begin
    lfsta_pkg::rsp_t got;
    lfsta_pkg::rsp_t exp_rsp;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        node_cnt[i] = 0;
        taken[i]    = 1'b0;
      end
      hint     = 0;
      limit_q  = lfsta_pkg::SLOT_LIMIT_RESET;
      fail_cnt = 0;
      due_responses.delete();
    end else begin
      if (cfg_wr_en) limit_q = cfg_wr_data;

      if (req_valid && !req_stall) begin
        due_responses.push_back(allocate_or_release(req));
      end

      // Compare an accepted response with the oldest prediction.
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (due_responses.size() == 0) begin
          $display("%0t: unexpected response: expected none, got status %0d granted %0d",
                   $time, got.status, got.granted);
          fail_cnt++;
        end else begin
          exp_rsp = due_responses.pop_front();
          if (got.status !== exp_rsp.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, exp_rsp.status, got.status);
            fail_cnt++;
          end
          if (got.granted !== exp_rsp.granted) begin
            $display("%0t: granted mismatch: expected %0d, got %0d",
                     $time, exp_rsp.granted, got.granted);
            fail_cnt++;
          end
        end
      end
    end
    pending <= due_responses.size();
  end

endmodule

// File: bench/lowest_free_slot_tree_allocator_test.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_tree_allocator_test: top of the allocator testbench
// Drives directed and random allocate and release transactions through
// several slot limit settings, with random gaps on both channels, and gives
// the verdict from the failure count of the response checker.
// ----------------------------------------------------------------------------
module lowest_free_slot_tree_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE  = 1023;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 80;

  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        cfg_wr_en   = 1'b0;
  logic [lfsta_pkg::IDX_W-1:0] cfg_wr_data = '0;
  logic                        req_valid   = 1'b0;
  logic                        req_stall;
  lfsta_pkg::req_t             req         = '0;
  logic                        rsp_valid;
  logic                        rsp_stall   = 1'b0;
  lfsta_pkg::rsp_t             rsp;

  int fail_cnt;
  int pending;
  int cycles     = 0;
  int stall_run  = 0;
  int stall_roll;

  always #6 clk = ~clk;

  lowest_free_slot_tree_allocator #(
    .TABLE_SIZE (TABLE_SIZE)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

  slot_grant_checker #(
    .TABLE_SIZE (TABLE_SIZE)
  ) grant_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .fail_cnt    (fail_cnt),
    .pending     (pending)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Response stall pattern: quiet stretches, short bursts and a few long holds.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if ((cycles % 4096) < 700) begin
      rsp_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        rsp_stall <= 1'b0;
        stall_run <= $urandom_range(0, 4);
      end else if (stall_roll < 94) begin
        rsp_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        rsp_stall <= 1'b1;
        stall_run <= $urandom_range(15, 50);
      end
    end
  end

  function automatic lfsta_pkg::req_t make_req(logic func, int want, int slot);
    lfsta_pkg::req_t r;
    r.func = func;
    r.want = lfsta_pkg::IDX_W'(want);
    r.slot = lfsta_pkg::IDX_W'(slot);
    return r;
  endfunction

  // Sender idle length: mostly none, sometimes short, rarely long.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic send(lfsta_pkg::req_t item);
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Send with a random idle stretch afterwards.
  task automatic send_gapped(lfsta_pkg::req_t item);
    int g;
    send(item);
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Wait until every predicted response has been accepted.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lfsta_pkg::IDX_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One random phase: the window keeps most requests near the busy region.
  task automatic run_phase(int limit, int count, int alloc_pct, int win);
    int   roll;
    int   want;
    int   slot;
    logic func;
    write_limit(limit);
    if (win > 1022) win = 1022;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 199) == 0) drain();
      func = ($urandom_range(0, 99) < alloc_pct) ? lfsta_pkg::FUNC_ALLOC
                                                 : lfsta_pkg::FUNC_RELEASE;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        want = $urandom_range(0, win / 4);
      end else if (roll < 85) begin
        want = $urandom_range(0, win);
      end else begin
        want = $urandom_range(0, 1022);
      end
      slot = ($urandom_range(0, 99) < 80) ? $urandom_range(0, win) : $urandom_range(0, 1022);
      send_gapped(make_req(func, want, slot));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed transactions at the reset limit.
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 0, 1022));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 0, 0));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 1022, 17));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 1022, 1022));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 512, 3));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 0, 341));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 1022, 1022));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 0, 1022));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 685, 700));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 1022, 1));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 0, 0));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 1022, 0));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 0, 0));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 0, 1));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 0, 2));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 0, 512));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 0, 1022));

    // Smallest limit: one usable slot, and a minimum at the bound.
    write_limit(1);
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 0, 1022));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 0, 0));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 1, 0));
    send_gapped(make_req(lfsta_pkg::FUNC_RELEASE, 1022, 0));
    send_gapped(make_req(lfsta_pkg::FUNC_ALLOC, 1022, 0));

    // Random phases over a range of limits, filling and draining the table.
    run_phase(1023, 450, 80, 600);
    run_phase(1023, 250, 30, 600);
    run_phase(7,    150, 60, 8);
    run_phase(64,   250, 65, 70);
    run_phase(1,    100, 50, 2);
    run_phase(300,  300, 55, 320);
    run_phase(1023, 250, 50, 1022);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
